[src/cell_chemotaxis_step_assert.svh]
// Assertion macros shared by the chemotaxis step engine modules.
`ifndef CELL_CHEMOTAXIS_STEP_ASSERT_SVH
`define CELL_CHEMOTAXIS_STEP_ASSERT_SVH

// Invariant that holds on every clock edge out of reset.
`define CC_ASSERT_HOLDS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/cc_pkg.sv]
// Shared types and constants for the chemotaxis step engine.
`timescale 1ns / 1ps
package cc_pkg;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 152;
    localparam int CFG_IDX_W  = 3;

    localparam logic [1:0] OP_TWR  = 2'd0;
    localparam logic [1:0] OP_INIT = 2'd1;
    localparam logic [1:0] OP_STEP = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [2:0] KIND_ZERO = 3'd0;
    localparam logic [2:0] KIND_ECHO = 3'd1;
    localparam logic [2:0] KIND_TWR  = 3'd2;
    localparam logic [2:0] KIND_INIT = 3'd3;
    localparam logic [2:0] KIND_STEP = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ALWAYS_UPD = 3'd6;

    localparam logic [63:0] EXPO_CAP = 64'd700 << 24;
    localparam logic [39:0] PATH_MAX = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [9:0]  cell_id;
        logic [11:0] tidx;
        logic [31:0] tval;
        logic [31:0] npos;
        logic [31:0] nvel;
        logic [15:0] rnd;
    } t_item;

    typedef struct packed {
        logic [31:0] left_bound;
        logic [31:0] right_bound;
        logic [31:0] inv_step;
        logic [12:0] table_len;
        logic [15:0] alpha;
        logic [30:0] speed;
        logic        upd_always;
    } t_cfg;

endpackage

[src/cc_ram.sv]
// Generic one-write one-read RAM with registered read data.
`timescale 1ns / 1ps
module cc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[src/cc_front.sv]
// Front end: unpacks and classifies input beats into a short queue.
`timescale 1ns / 1ps
`include "cell_chemotaxis_step_assert.svh"
module cc_front #(
    parameter int NUM_CELLS   = 1024,
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [cc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic [1:0]                  s_axis_tuser,
    input  logic                        i_pop,
    output logic                        o_head_vld,
    output cc_pkg::t_item               o_head
);
    import cc_pkg::*;

    localparam int QDepth = 4;

    t_item       r_q [QDepth];
    logic [1:0]  r_wp;
    logic [1:0]  r_rp;
    logic [2:0]  r_cnt;
    t_item       n_item;
    logic        push;

    always_comb begin
        n_item.cell_id = s_axis_tdata[9:0];
        n_item.tidx    = s_axis_tdata[21:10];
        n_item.tval    = s_axis_tdata[53:22];
        n_item.npos    = s_axis_tdata[85:54];
        n_item.nvel    = s_axis_tdata[117:86];
        n_item.rnd     = s_axis_tdata[133:118];
        case (s_axis_tuser)
            OP_TWR: begin
                n_item.kind = (32'(n_item.tidx) < 32'(TABLE_DEPTH)) ? KIND_TWR : KIND_ZERO;
            end
            OP_INIT, OP_STEP: begin
                if (32'(n_item.cell_id) < 32'(NUM_CELLS)) begin
                    n_item.kind = (s_axis_tuser == OP_INIT) ? KIND_INIT : KIND_STEP;
                end else begin
                    n_item.kind = KIND_ECHO;
                end
            end
            default: n_item.kind = KIND_ZERO;
        endcase
    end

    assign s_axis_tready = (r_cnt != 3'(QDepth));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_head_vld    = (r_cnt != 3'd0);
    assign o_head        = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(push) - 3'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_item;
        end
    end

    `CC_ASSERT_HOLDS(a_q_bound, i_clk, i_rst_n, r_cnt <= 3'(QDepth), "queue overflow")
    `CC_ASSERT_NEXT(a_q_fill, i_clk, i_rst_n, push && !i_pop, r_cnt == $past(r_cnt) + 3'd1, "queue count slip")
endmodule

[src/cc_back.sv]
// Back end: in-order pipeline that executes table writes, cell setup and steps.
`timescale 1ns / 1ps
`include "cell_chemotaxis_step_assert.svh"
module cc_back #(
    parameter int NUM_CELLS     = 1024,
    parameter int TABLE_DEPTH   = 4096,
    parameter int SIGMA_ENTRIES = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cc_pkg::t_cfg                 i_cfg,
    input  logic                         i_head_vld,
    input  cc_pkg::t_item                i_head,
    output logic                         o_pop,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [cc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import cc_pkg::*;

    localparam int CellAw = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int TabAw  = $clog2(TABLE_DEPTH);
    localparam int RomAw  = $clog2(SIGMA_ENTRIES);

    typedef logic [SIGMA_ENTRIES-1:0][15:0] t_rom;

    // elaboration-time long division for the ROM build
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] e31;
        logic [63:0] p;
        logic [63:0] q;
        rom  = '0;
        term = 64'd1 << 58;
        sum  = term;
        for (int k = 1; k <= 40; k++) begin
            term = udiv64(term * 64'd16, 64'(SIGMA_ENTRIES) * 64'(k));
            if ((k & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        e31 = (sum + (64'd1 << 26)) >> 27;
        p   = 64'd1 << 31;
        for (int i = 0; i < SIGMA_ENTRIES; i++) begin
            q = (udiv64(64'd1 << 48, (64'd1 << 31) + p) + 64'd1) >> 1;
            rom[i] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
            p = (p * e31 + (64'd1 << 30)) >> 31;
        end
        return rom;
    endfunction

    localparam t_rom SigmaRom = build_rom();

    logic        ce;
    logic        hazard;
    logic        head_cell;
    t_item       r_it  [1:9];
    logic        r_vld [1:9];

    logic [31:0] pos_q, vel_q, org_q, grad_q;
    logic [39:0] path_q;

    logic [31:0] r_pos  [2:8];
    logic [31:0] r_vel  [2:8];
    logic [31:0] r_org  [2:9];
    logic [39:0] r_path [2:8];
    logic        r_gpos [5:7];
    logic [32:0] r_d;
    logic [63:0] r_prod;
    logic [47:0] r_expo;
    logic [15:0] r_sigma;
    logic [30:0] r_mag;
    logic        r_upd;
    logic [31:0] r_newv;
    logic [31:0] r9_pos, r9_vel;
    logic [39:0] r9_path;

    logic        r_out_vld;
    logic [9:0]  r_out_cell;
    logic [31:0] r_out_pos, r_out_vel, r_out_disp;
    logic [39:0] r_out_path;

    // stage combinational values
    logic [32:0] s1_d;
    logic [63:0] s2_prod;
    logic [32:0] s3_idx, s3_len, s3_idxc;
    logic        s3_twr;
    logic [31:0] s4_absg;
    logic [63:0] s5_capped, s5_scaled;
    logic [RomAw-1:0] s5_ridx;
    logic [46:0] s6_prod;
    logic [31:0] s7_mag, s7_newv;
    logic [31:0] s8_absv, s8_pos, w_pos, w_vel;
    logic [40:0] s8_psum;
    logic [39:0] w_path;
    logic [32:0] s8_sum;
    logic        s8_wr, s8_init;
    logic [32:0] o_dd, o_abs;
    logic        o_full;

    function automatic logic is_cell(input logic [2:0] kind);
        return (kind == KIND_INIT) || (kind == KIND_STEP);
    endfunction

    assign ce        = !r_out_vld || m_axis_tready;
    assign head_cell = is_cell(i_head.kind);

    always_comb begin
        hazard = 1'b0;
        for (int k = 1; k <= 8; k++) begin
            if (r_vld[k] && is_cell(r_it[k].kind) && (r_it[k].cell_id == i_head.cell_id)) begin
                hazard = 1'b1;
            end
        end
    end

    assign o_pop = ce && i_head_vld && !(head_cell && hazard);

    // stage 1: grid offset
    assign s1_d = 33'($signed({pos_q[31], pos_q}) -
                      $signed({i_cfg.left_bound[31], i_cfg.left_bound}));

    // stage 2: scale by reciprocal spacing
    assign s2_prod = (!r_d[32] && (r_d != 33'd0)) ?
                     (64'(r_d[31:0]) * 64'(i_cfg.inv_step)) : 64'd0;

    // stage 3: round, clamp, gradient lookup and table write
    always_comb begin
        s3_idx = {1'b0, r_prod[63:32]} + 33'(r_prod[31]);
        if (i_cfg.table_len == 13'd0) begin
            s3_len = 33'd1;
        end else if (33'(i_cfg.table_len) > 33'(TABLE_DEPTH)) begin
            s3_len = 33'(TABLE_DEPTH);
        end else begin
            s3_len = 33'(i_cfg.table_len);
        end
        s3_idxc = (s3_idx > s3_len - 33'd1) ? (s3_len - 33'd1) : s3_idx;
    end
    assign s3_twr = ce && r_vld[3] && (r_it[3].kind == KIND_TWR);

    // stage 4: gain times |gradient|
    assign s4_absg = grad_q[31] ? (~grad_q + 32'd1) : grad_q;

    // stage 5: sigma ROM
    always_comb begin
        s5_capped = (64'(r_expo) > EXPO_CAP) ? EXPO_CAP : 64'(r_expo);
        s5_scaled = (s5_capped * 64'(SIGMA_ENTRIES)) >> 28;
        s5_ridx   = (s5_scaled > 64'(SIGMA_ENTRIES - 1)) ?
                    RomAw'(SIGMA_ENTRIES - 1) : RomAw'(s5_scaled);
    end

    // stage 6: speed magnitude
    assign s6_prod = (47'(r_sigma) * 47'(i_cfg.speed)) + 47'd32768;

    // stage 7: new velocity
    assign s7_mag  = {1'b0, r_mag};
    assign s7_newv = r_upd ? (r_gpos[7] ? s7_mag : (~s7_mag + 32'd1)) : r_vel[7];

    // stage 8: path, move, respawn, write back
    always_comb begin
        s8_init = (r_it[8].kind == KIND_INIT);
        s8_absv = r_newv[31] ? (~r_newv + 32'd1) : r_newv;
        s8_psum = {1'b0, r_path[8]} + 41'(s8_absv);
        s8_sum  = 33'($signed({r_pos[8][31], r_pos[8]}) + $signed({r_newv[31], r_newv}));
        if (($signed(s8_sum) < $signed({i_cfg.left_bound[31], i_cfg.left_bound})) ||
            ($signed(s8_sum) > $signed({i_cfg.right_bound[31], i_cfg.right_bound}))) begin
            s8_pos = r_it[8].npos;
        end else begin
            s8_pos = s8_sum[31:0];
        end
        w_pos  = s8_init ? r_it[8].npos : s8_pos;
        w_vel  = s8_init ? r_it[8].nvel : r_newv;
        w_path = s8_init ? 40'd0 : (s8_psum[40] ? PATH_MAX : s8_psum[39:0]);
    end
    assign s8_wr = ce && r_vld[8] && is_cell(r_it[8].kind);

    // output stage: displacement
    always_comb begin
        o_dd   = 33'($signed({r9_pos[31], r9_pos}) - $signed({r_org[9][31], r_org[9]}));
        o_abs  = o_dd[32] ? (~o_dd + 33'd1) : o_dd;
        o_full = is_cell(r_it[9].kind);
    end

    cc_ram #(.WIDTH(32), .DEPTH(NUM_CELLS)) u_pos_ram (
        .i_clk(i_clk), .i_we(s8_wr), .i_waddr(CellAw'(r_it[8].cell_id)), .i_wdata(w_pos),
        .i_re(ce), .i_raddr(CellAw'(i_head.cell_id)), .o_rdata(pos_q)
    );
    cc_ram #(.WIDTH(32), .DEPTH(NUM_CELLS)) u_vel_ram (
        .i_clk(i_clk), .i_we(s8_wr), .i_waddr(CellAw'(r_it[8].cell_id)), .i_wdata(w_vel),
        .i_re(ce), .i_raddr(CellAw'(i_head.cell_id)), .o_rdata(vel_q)
    );
    cc_ram #(.WIDTH(32), .DEPTH(NUM_CELLS)) u_org_ram (
        .i_clk(i_clk), .i_we(s8_wr && s8_init), .i_waddr(CellAw'(r_it[8].cell_id)),
        .i_wdata(r_it[8].npos),
        .i_re(ce), .i_raddr(CellAw'(i_head.cell_id)), .o_rdata(org_q)
    );
    cc_ram #(.WIDTH(40), .DEPTH(NUM_CELLS)) u_path_ram (
        .i_clk(i_clk), .i_we(s8_wr), .i_waddr(CellAw'(r_it[8].cell_id)), .i_wdata(w_path),
        .i_re(ce), .i_raddr(CellAw'(i_head.cell_id)), .o_rdata(path_q)
    );
    cc_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_grad_ram (
        .i_clk(i_clk), .i_we(s3_twr), .i_waddr(TabAw'(r_it[3].tidx)), .i_wdata(r_it[3].tval),
        .i_re(ce), .i_raddr(TabAw'(s3_idxc)), .o_rdata(grad_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 9; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (ce) begin
            r_vld[1] <= o_pop;
            for (int k = 2; k <= 9; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_vld <= r_vld[9];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_it[1] <= i_head;
            for (int k = 2; k <= 9; k++) begin
                r_it[k] <= r_it[k-1];
            end
            r_pos[2]  <= pos_q;
            r_vel[2]  <= vel_q;
            r_org[2]  <= org_q;
            r_path[2] <= path_q;
            for (int k = 3; k <= 8; k++) begin
                r_pos[k]  <= r_pos[k-1];
                r_vel[k]  <= r_vel[k-1];
                r_org[k]  <= r_org[k-1];
                r_path[k] <= r_path[k-1];
            end
            r_d      <= s1_d;
            r_prod   <= s2_prod;
            r_expo   <= 48'(i_cfg.alpha) * 48'(s4_absg);
            r_gpos[5] <= !grad_q[31] && (grad_q != 32'd0);
            r_gpos[6] <= r_gpos[5];
            r_gpos[7] <= r_gpos[6];
            r_sigma  <= SigmaRom[s5_ridx];
            r_mag    <= s6_prod[46:16];
            r_upd    <= i_cfg.upd_always || (r_it[6].rnd < r_sigma);
            r_newv   <= s7_newv;
            r9_pos   <= w_pos;
            r9_vel   <= w_vel;
            r9_path  <= w_path;
            r_org[9] <= s8_init ? r_it[8].npos : r_org[8];
            r_out_cell <= (o_full || (r_it[9].kind == KIND_ECHO)) ? r_it[9].cell_id : 10'd0;
            r_out_pos  <= o_full ? r9_pos : 32'd0;
            r_out_vel  <= o_full ? r9_vel : 32'd0;
            r_out_path <= o_full ? r9_path : 40'd0;
            r_out_disp <= o_full ? o_abs[31:0] : 32'd0;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_out_disp, r_out_path, r_out_vel, r_out_pos, r_out_cell};

    `CC_ASSERT_HOLDS(a_one_writer, i_clk, i_rst_n, !(r_vld[1] && r_vld[8] && is_cell(r_it[1].kind) && is_cell(r_it[8].kind) && (r_it[1].cell_id == r_it[8].cell_id)), "same cell issued while write pending")
    `CC_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, ce && r_vld[9], r_out_vld, "result lost at output stage")
endmodule

[src/cell_chemotaxis_step.sv]
// Top level of the chemotaxis step engine: config registers, front end, back end.
//
//  channel   dir  handshake          payload
//  s_axis    in   tvalid/tready      tuser: op; tdata: cell_req .. rand_p
//  m_axis    out  tvalid/tready      tdata: out_cell .. displacement
//  cfg       in   i_cfg_we           i_cfg_idx, i_cfg_wdata
//
//  One beat per cycle while the output is not stalled and no hazard holds the head;
//  each beat passes the queue and nine pipeline stages before its result is presented.
//  Init or step beats on a cell still in stages 1 to 8, up to its write-back,
//  wait at the queue head, so beats on one cell issue only after the last leaves stage 8.
//  Output back-pressure freezes the whole back end; the 4-deep queue keeps
//  accepting until full. Synchronous active-low reset; no clearing pass.
`timescale 1ns / 1ps
module cell_chemotaxis_step #(
    parameter int NUM_CELLS     = 1024,
    parameter int TABLE_DEPTH   = 4096,
    parameter int SIGMA_ENTRIES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // cell_req[9:0], table_index[21:10], table_value[53:22], new_position[85:54],
    // new_velocity[117:86], rand_p[133:118], zero pad
    input  logic [cc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_cell[9:0], position[41:10], velocity[73:42], travelled[113:74],
    // displacement[145:114], zero pad
    output logic [cc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [cc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [31:0]                   i_cfg_wdata
);
    import cc_pkg::*;

    t_cfg  r_cfg;
    logic  head_vld;
    logic  pop;
    t_item head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_bound    <= 32'd0;
            r_cfg.right_bound   <= 32'h7FFF_FFFF;
            r_cfg.inv_step      <= 32'd65536;
            r_cfg.table_len     <= 13'd4096;
            r_cfg.alpha         <= 16'd256;
            r_cfg.speed         <= 31'd65536;
            r_cfg.upd_always    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_START: r_cfg.left_bound    <= i_cfg_wdata;
                CFG_GRID_END:   r_cfg.right_bound   <= i_cfg_wdata;
                CFG_INV_STEP:   r_cfg.inv_step      <= i_cfg_wdata;
                CFG_TABLE_LEN:  r_cfg.table_len     <= i_cfg_wdata[12:0];
                CFG_ALPHA:      r_cfg.alpha         <= i_cfg_wdata[15:0];
                CFG_SPEED:      r_cfg.speed         <= i_cfg_wdata[30:0];
                CFG_ALWAYS_UPD: r_cfg.upd_always    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    cc_front #(
        .NUM_CELLS(NUM_CELLS),
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .i_pop(pop),
        .o_head_vld(head_vld),
        .o_head(head)
    );

    cc_back #(
        .NUM_CELLS(NUM_CELLS),
        .TABLE_DEPTH(TABLE_DEPTH),
        .SIGMA_ENTRIES(SIGMA_ENTRIES)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(r_cfg),
        .i_head_vld(head_vld),
        .i_head(head),
        .o_pop(pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );
endmodule

[bench/tb_cell_chemotaxis_step.sv]
// Self-checking bench for cell_chemotaxis_step: stream stimulus, in-bench predictor, result check.
`timescale 1ns / 1ps
module tb_cell_chemotaxis_step;
    import cc_pkg::*;

    localparam int N_CELLS    = 1024;
    localparam int TBL_DEPTH  = 4096;
    localparam int SIG_N      = 256;
    localparam int DRAIN_WAIT = 40;
    localparam int CYCLE_CAP  = 400000;

    typedef struct {
        logic [9:0]  cell_id;
        logic [31:0] pos;
        logic [31:0] vel;
        logic [39:0] trav;
        logic [31:0] disp;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [31:0]           i_cfg_wdata = '0;

    cell_chemotaxis_step dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    int               grad_mem [TBL_DEPTH];
    bit               grad_set [TBL_DEPTH];
    int               c_pos [N_CELLS];
    int               c_vel [N_CELLS];
    int               c_orig [N_CELLS];
    longint unsigned  c_path [N_CELLS];
    bit               c_live [N_CELLS];
    longint unsigned  sigma_lut [SIG_N];

    int               r_start;
    int               r_end;
    longint unsigned  r_inv;
    int               r_len;
    longint unsigned  r_alpha;
    longint unsigned  r_speed;
    bit               r_always;

    // newest at the front, oldest at the back
    t_result pending_results [$];
    int      mismatches = 0;
    int      cycles = 0;
    bit      idle_on = 1'b1;
    bit      hold_req = 1'b0;
    int      rx_gap = 0;
    int      hold_left = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = 300;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0)
                rx_gap = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 50)
                                                      : $urandom_range(1, 3);
        end
    end

    // result check: sampled mid-cycle, beat completes at the next rising edge
    always @(negedge i_clk) begin
        t_result e;
        t_result a;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            a.cell_id = m_axis_tdata[9:0];
            a.pos     = m_axis_tdata[41:10];
            a.vel     = m_axis_tdata[73:42];
            a.trav    = m_axis_tdata[113:74];
            a.disp    = m_axis_tdata[145:114];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat cell=%0d pos=%h", a.cell_id, a.pos);
            end else begin
                e = pending_results.pop_back();
                if (e.cell_id !== a.cell_id || e.pos !== a.pos || e.vel !== a.vel ||
                    e.trav !== a.trav || e.disp !== a.disp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp cell=%0d pos=%h vel=%h trav=%h disp=%h | %s%0d %h %h %h %h",
                                 e.cell_id, e.pos, e.vel, e.trav, e.disp, "got cell=",
                                 a.cell_id, a.pos, a.vel, a.trav, a.disp);
                end
            end
        end
    end

    function automatic void build_sigma_lut();
        longint unsigned term;
        longint unsigned acc;
        longint unsigned e31;
        longint unsigned p;
        longint unsigned q;
        term = 64'd1 << 58;
        acc = term;
        for (int k = 1; k <= 40; k++) begin
            term = term * 16 / (SIG_N * k);
            if (k % 2 == 1) acc = acc - term;
            else acc = acc + term;
        end
        e31 = (acc + (64'd1 << 26)) >> 27;
        p = 64'd1 << 31;
        for (int i = 0; i < SIG_N; i++) begin
            q = (((64'd1 << 48) / ((64'd1 << 31) + p)) + 1) >> 1;
            sigma_lut[i] = (q > 65535) ? 65535 : q;
            p = (p * e31 + (64'd1 << 30)) >> 31;
        end
    endfunction

    function automatic int gradient_slot(int c);
        longint          d;
        longint unsigned prod;
        longint unsigned idx;
        longint unsigned len;
        len = (r_len < 1) ? 1 : (r_len > TBL_DEPTH) ? TBL_DEPTH : r_len;
        idx = 0;
        d = longint'(c_pos[c]) - longint'(r_start);
        if (d > 0) begin
            prod = longint'(d) * r_inv;
            idx = (prod >> 32) + ((prod >> 31) & 1);
        end
        if (idx > len - 1) idx = len - 1;
        return int'(idx);
    endfunction

    function automatic t_result chemotaxis_result(logic [1:0] op, int c, int tidx, int tval,
                                                  int npos, int nvel, int rnd);
        t_result         r;
        int              g;
        longint unsigned expo;
        longint unsigned ridx;
        longint unsigned sig;
        longint unsigned mag;
        longint unsigned path;
        longint          newv;
        longint          sum;
        longint          disp;
        r = '{default: '0};
        c = c & 32'h3FF;
        tidx = tidx & 32'hFFF;
        rnd = rnd & 32'hFFFF;
        if (op == OP_TWR) begin
            if (tidx < TBL_DEPTH) begin
                grad_mem[tidx] = tval;
                grad_set[tidx] = 1'b1;
            end
            return r;
        end
        if (op != OP_INIT && op != OP_STEP) return r;
        r.cell_id = 10'(c);
        if (op == OP_INIT) begin
            c_pos[c] = npos;
            c_vel[c] = nvel;
            c_orig[c] = npos;
            c_path[c] = 0;
            c_live[c] = 1'b1;
        end else begin
            g = grad_mem[gradient_slot(c)];
            expo = r_alpha * ((g < 0) ? longint'(-longint'(g)) : longint'(g));
            if (expo > EXPO_CAP) expo = EXPO_CAP;
            ridx = (expo * SIG_N) >> 28;
            if (ridx > SIG_N - 1) ridx = SIG_N - 1;
            sig = sigma_lut[ridx];
            newv = c_vel[c];
            if (r_always || rnd < sig) begin
                mag = (sig * r_speed + 32768) >> 16;
                newv = (g > 0) ? longint'(mag) : -longint'(mag);
            end
            c_vel[c] = int'(newv);
            path = c_path[c] + ((newv < 0) ? -newv : newv);
            c_path[c] = (path > PATH_MAX) ? PATH_MAX : path;
            sum = longint'(c_pos[c]) + newv;
            if (sum < r_start || sum > r_end) sum = npos;
            c_pos[c] = int'(sum);
        end
        disp = longint'(c_pos[c]) - longint'(c_orig[c]);
        if (disp < 0) disp = -disp;
        r.pos = c_pos[c];
        r.vel = c_vel[c];
        r.trav = 40'(c_path[c]);
        r.disp = disp[31:0];
        return r;
    endfunction

    function automatic int sender_gap();
        if (!idle_on || $urandom_range(0, 2) != 0) return 0;
        return ($urandom_range(0, 20) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
    endfunction

    task automatic send_item(logic [1:0] op, int c, int tidx, int tval, int npos,
                             int nvel, int rnd);
        int gap;
        bit took;
        gap = sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pending_results.push_front(chemotaxis_result(op, c, tidx, tval, npos, nvel, rnd));
        s_axis_tuser <= op;
        s_axis_tdata <= {2'b0, 16'(rnd), 32'(nvel), 32'(npos), 32'(tval), 12'(tidx), 10'(c)};
        s_axis_tvalid <= 1'b1;
        do begin
            @(negedge i_clk);
            took = s_axis_tready;
            @(posedge i_clk);
        end while (!took);
    endtask

    // any gradient slot a step will read gets written first
    task automatic step_cell(int c, int npos, int rnd);
        int slot;
        if (!c_live[c])
            send_item(OP_INIT, c, 0, 0, npos, $urandom, 0);
        slot = gradient_slot(c);
        if (!grad_set[slot])
            send_item(OP_TWR, 0, slot, $urandom, 0, 0, 0);
        send_item(OP_STEP, c, $urandom, $urandom, npos, $urandom, rnd);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_GRID_START: r_start = val;
            CFG_GRID_END:   r_end = val;
            CFG_INV_STEP:   r_inv = longint'(val) & 64'hFFFF_FFFF;
            CFG_TABLE_LEN:  r_len = val & 32'h1FFF;
            CFG_ALPHA:      r_alpha = val & 32'hFFFF;
            CFG_SPEED:      r_speed = val & 32'h7FFF_FFFF;
            CFG_ALWAYS_UPD: r_always = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_config(int gs, int ge, int inv, int len, int al, int sp, int au);
        drain();
        write_reg(CFG_GRID_START, gs);
        write_reg(CFG_GRID_END, ge);
        write_reg(CFG_INV_STEP, inv);
        write_reg(CFG_TABLE_LEN, len);
        write_reg(CFG_ALPHA, al);
        write_reg(CFG_SPEED, sp);
        write_reg(CFG_ALWAYS_UPD, au);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int field_pick(int lo, int hi);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            default: return $urandom;
        endcase
    endfunction

    function automatic int spawn_pos();
        longint span;
        span = longint'(r_end) - longint'(r_start);
        if (span < 0 || $urandom_range(0, 3) == 0) return $urandom;
        return int'(longint'(r_start) + ({$urandom, $urandom} % (span + 1)));
    endfunction

    task automatic random_items(int n);
        int c;
        for (int i = 0; i < n; i++) begin
            c = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom_range(0, N_CELLS - 1);
            case ($urandom_range(0, 19))
                0, 1:    send_item(OP_TWR, $urandom, $urandom, field_pick(32'h8000_0000,
                                   32'h7FFF_FFFF), $urandom, $urandom, $urandom);
                2, 3, 4: send_item(OP_INIT, c, $urandom, $urandom, spawn_pos(),
                                   field_pick(32'h8000_0000, 32'h7FFF_FFFF), $urandom);
                5:       send_item(OP_NOP, $urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom);
                default: step_cell(c, spawn_pos(), $urandom_range(0, 65535));
            endcase
        end
    endtask

    task automatic test_directed();
        send_item(OP_TWR, 0, 0, 32'h7FFF_FFFF, 0, 0, 0);
        send_item(OP_TWR, 0, TBL_DEPTH - 1, 32'h8000_0000, 0, 0, 0);
        send_item(OP_TWR, 0, 1, 0, 0, 0, 0);
        send_item(OP_NOP, 10'h3FF, 12'hFFF, -1, -1, -1, 16'hFFFF);
        send_item(OP_INIT, 0, 0, 0, 0, 32'h7FFF_FFFF, 0);
        send_item(OP_INIT, N_CELLS - 1, 0, 0, 32'h8000_0000, 32'h8000_0000, 0);
        send_item(OP_INIT, 5, 0, 0, 32'h7FFF_FFFF, 0, 0);
        step_cell(0, 0, 0);
        step_cell(N_CELLS - 1, 32'h8000_0000, 16'hFFFF);
        step_cell(5, 1234, 0);
        step_cell(0, 0, 0);
        step_cell(0, 0, 0);
        step_cell(0, 32'h7FFF_FFFF, 0);
        // update by chance only, sigma fixed at one half
        write_config(0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0);
        step_cell(5, 77, 0);
        step_cell(5, 77, 16'hFFFF);
        step_cell(5, 77, 32767);
        step_cell(5, 77, 32768);
        // crossed grid edges: every step respawns
        write_config(1000, -1000, 32'hFFFF_FFFF, 8191, 16'hFFFF, 65536, 1);
        step_cell(0, 555, 0);
        step_cell(N_CELLS - 1, -555, 0);
        step_cell(5, 0, 0);
    endtask

    task automatic test_path_saturation();
        write_config(32'h8000_0000, 32'h7FFF_FFFF, 65536, 1, 256, 65536, 0);
        send_item(OP_INIT, 2, 0, 0, 0, 32'h8000_0000, 0);
        for (int i = 0; i < 520; i++) step_cell(2, $urandom, 16'hFFFF);
    endtask

    task automatic test_random_configs();
        for (int ph = 0; ph < 4; ph++) begin
            idle_on = (ph != 2);
            write_config(field_pick(32'h8000_0000, 32'h7FFF_FFFF),
                         field_pick(32'h8000_0000, 32'h7FFF_FFFF),
                         ($urandom_range(0, 1) == 0) ? $urandom_range(0, 32'h0004_0000)
                                                     : field_pick(0, -1),
                         $urandom_range(0, 8191), field_pick(0, 65535),
                         $urandom_range(0, 32'h7FFF_FFFF), $urandom_range(0, 1));
            random_items(110);
        end
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        write_config(0, 32'h7FFF_FFFF, 65536, 4096, 256, 65536, 1);
        idle_on = 1'b0;
        hold_req = 1'b1;
        random_items(40);
        idle_on = 1'b1;
    endtask

    initial begin
        build_sigma_lut();
        r_start = 0;
        r_end = 32'h7FFF_FFFF;
        r_inv = 65536;
        r_len = 4096;
        r_alpha = 256;
        r_speed = 65536;
        r_always = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_path_saturation();
        test_random_configs();
        test_backpressure();
        drain();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
